FILE: rtl/aspd_pkg.sv
// ----------------------------------------------------------------------------
// aspd_pkg
// shared types and constants for the accelerometer spike peak detector
// ----------------------------------------------------------------------------
package aspd_pkg;

    localparam int SAMPLE_W = 8;
    localparam int THR_W    = 8;
    localparam int LEVEL_W  = 2;

    localparam int LQ_DEPTH = 4;
    localparam int LQ_AW    = 2;
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = 1;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_LVL3_THR = 2'd0;
    localparam logic [1:0] REG_LVL2_THR = 2'd1;
    localparam logic [1:0] REG_LVL1_THR = 2'd2;

    localparam logic [THR_W-1:0] LVL3_THR_RST = 8'd190;
    localparam logic [THR_W-1:0] LVL2_THR_RST = 8'd125;
    localparam logic [THR_W-1:0] LVL1_THR_RST = 8'd90;

    typedef struct packed {
        logic [THR_W-1:0] lvl3;
        logic [THR_W-1:0] lvl2;
        logic [THR_W-1:0] lvl1;
    } t_thr;

    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
    } t_lvl_word;

endpackage

FILE: rtl/accel_spike_peak_detector_unit.sv
// ----------------------------------------------------------------------------
// accel_spike_peak_detector_unit
// accelerometer spike detector reporting the peak level of each spike
// ----------------------------------------------------------------------------
// samples come in on a queue-style port: a word is taken when i_push is high
// and o_full is low. each sample's largest axis magnitude is quantized to a
// level 0..3 against three thresholds and queued for the phase machine.
// a peak level word is produced when a spike's fall is confirmed; it sits on
// o_peak_level while o_empty is low and leaves when i_pop is high.
// throughput is one sample per cycle while the result queue has room or is popped.
// a sample's level is registered in the level queue, its result in the result queue.
// a four-entry level queue and a two-entry result queue let both sides
// stall on their own; while the receiver stalls, levels build up in the
// queue and o_full rises once both queues are full.
// thresholds sit on an apb port at byte addresses 0, 4 and 8; writes are
// meant only while the block is idle.
// synchronous reset empties both queues, returns the phase machine to idle
// and loads the thresholds 190, 125 and 90.
// ----------------------------------------------------------------------------
module accel_spike_peak_detector_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic signed [aspd_pkg::SAMPLE_W-1:0] i_accel_x,
    input  logic signed [aspd_pkg::SAMPLE_W-1:0] i_accel_y,
    input  logic signed [aspd_pkg::SAMPLE_W-1:0] i_accel_z,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic [aspd_pkg::LEVEL_W-1:0]         o_peak_level,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [aspd_pkg::APB_AW-1:0]          paddr,
    input  logic [aspd_pkg::APB_DW-1:0]          pwdata,
    output logic [aspd_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);
    import aspd_pkg::*;

    t_thr      r_thr;
    t_lvl_word lvl;
    logic      lvl_pop, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.lvl3 <= LVL3_THR_RST;
            r_thr.lvl2 <= LVL2_THR_RST;
            r_thr.lvl1 <= LVL1_THR_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LVL3_THR: r_thr.lvl3 <= pwdata[THR_W-1:0];
                REG_LVL2_THR: r_thr.lvl2 <= pwdata[THR_W-1:0];
                REG_LVL1_THR: r_thr.lvl1 <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LVL3_THR: prdata = {{(APB_DW-THR_W){1'b0}}, r_thr.lvl3};
            REG_LVL2_THR: prdata = {{(APB_DW-THR_W){1'b0}}, r_thr.lvl2};
            REG_LVL1_THR: prdata = {{(APB_DW-THR_W){1'b0}}, r_thr.lvl1};
            default:      prdata = '0;
        endcase
    end

    aspd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .o_full    (o_full),
        .i_accel_x (i_accel_x),
        .i_accel_y (i_accel_y),
        .i_accel_z (i_accel_z),
        .i_thr     (r_thr),
        .o_lvl     (lvl),
        .i_lvl_pop (lvl_pop)
    );

    aspd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lvl        (lvl),
        .o_lvl_pop    (lvl_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_peak_level (o_peak_level)
    );

endmodule

FILE: rtl/aspd_front.sv
// ----------------------------------------------------------------------------
// aspd_front
// takes samples, forms the axis magnitude, quantizes it and queues the level
// ----------------------------------------------------------------------------
module aspd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic signed [aspd_pkg::SAMPLE_W-1:0] i_accel_x,
    input  logic signed [aspd_pkg::SAMPLE_W-1:0] i_accel_y,
    input  logic signed [aspd_pkg::SAMPLE_W-1:0] i_accel_z,
    input  aspd_pkg::t_thr                  i_thr,
    output aspd_pkg::t_lvl_word             o_lvl,
    input  logic                            i_lvl_pop
);
    import aspd_pkg::*;

    logic [SAMPLE_W-1:0] mag_x, mag_y, mag_z, mag_xy, mag;
    logic [LEVEL_W-1:0]  level;
    logic                wr_en, rd_en;

    logic [LEVEL_W-1:0] r_lq [0:LQ_DEPTH-1];
    logic [LQ_AW-1:0]   r_wp, r_rp, n_wp, n_rp;
    logic [LQ_AW:0]     r_cnt, n_cnt;

    // plain magnitude, -128 maps to 128
    assign mag_x  = i_accel_x[SAMPLE_W-1] ? (~i_accel_x + 1'b1) : i_accel_x;
    assign mag_y  = i_accel_y[SAMPLE_W-1] ? (~i_accel_y + 1'b1) : i_accel_y;
    assign mag_z  = i_accel_z[SAMPLE_W-1] ? (~i_accel_z + 1'b1) : i_accel_z;
    assign mag_xy = (mag_y > mag_x) ? mag_y : mag_x;
    assign mag    = (mag_z > mag_xy) ? mag_z : mag_xy;

    always_comb begin
        if (mag > i_thr.lvl3) begin
            level = 2'd3;
        end else if (mag > i_thr.lvl2) begin
            level = 2'd2;
        end else if (mag > i_thr.lvl1) begin
            level = 2'd1;
        end else begin
            level = 2'd0;
        end
    end

    assign o_full  = (r_cnt == (LQ_AW+1)'(LQ_DEPTH));
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_lvl_pop && (r_cnt != '0);
    assign o_lvl.valid = (r_cnt != '0);
    assign o_lvl.level = r_lq[r_rp];

    always_comb begin
        n_wp  = wr_en ? r_wp + 1'b1 : r_wp;
        n_rp  = rd_en ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!wr_en && rd_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_lq[r_wp] <= level;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (LQ_AW+1)'(LQ_DEPTH))
        else $error("level queue count out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == (LQ_AW+1)'(LQ_DEPTH)) |-> (r_wp == r_rp))
        else $error("level queue pointers disagree with count");

    a_pop_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_lvl_pop |-> (r_cnt != '0))
        else $error("level popped from an empty queue");

endmodule

FILE: rtl/aspd_back.sv
// ----------------------------------------------------------------------------
// aspd_back
// phase machine over queued levels, emits peak levels into the result queue
// ----------------------------------------------------------------------------
module aspd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  aspd_pkg::t_lvl_word           i_lvl,
    output logic                          o_lvl_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [aspd_pkg::LEVEL_W-1:0]  o_peak_level
);
    import aspd_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_RISE  = 3'd2;
    localparam logic [2:0] PH_FALL  = 3'd3;
    localparam logic [2:0] PH_QUIET = 3'd4;

    logic [2:0]         r_phase, n_phase;
    logic [LEVEL_W-1:0] r_peak, n_peak, peak_tmp, lvl;
    logic               emit, step, res_push, res_pop, oq_full;

    logic [LEVEL_W-1:0] r_oq [0:OQ_DEPTH-1];
    logic [OQ_AW-1:0]   r_owp, r_orp;
    logic [OQ_AW:0]     r_ocnt, n_ocnt;

    assign lvl      = i_lvl.level;
    assign oq_full  = (r_ocnt == (OQ_AW+1)'(OQ_DEPTH));
    assign res_pop  = i_pop && !o_empty;
    assign step     = i_lvl.valid && (!oq_full || res_pop);
    assign o_lvl_pop = step;
    assign res_push = step && emit;

    always_comb begin
        n_phase  = r_phase;
        n_peak   = r_peak;
        emit     = 1'b0;
        peak_tmp = r_peak;
        case (r_phase)
            PH_IDLE: begin
                if (lvl != '0) begin
                    n_phase = PH_START;
                    n_peak  = '0;
                end
            end
            PH_START: begin
                if (lvl != '0) begin
                    n_phase = PH_RISE;
                    n_peak  = lvl;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_RISE: begin
                if (lvl < r_peak) begin
                    n_phase = PH_FALL;
                end
                if (r_peak < lvl) begin
                    n_peak = lvl;
                end
            end
            PH_FALL: begin
                if (lvl < r_peak) begin
                    emit     = 1'b1;
                    n_phase  = PH_QUIET;
                    peak_tmp = '0;
                end
                n_peak = peak_tmp;
                // tested after the emit, so a live level climbs again
                if (lvl > peak_tmp) begin
                    n_phase = PH_RISE;
                    n_peak  = lvl;
                end
            end
            PH_QUIET: begin
                if (lvl == '0) begin
                    if (r_peak != '0) begin
                        n_peak = '0;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ocnt = r_ocnt;
        if (res_push && !res_pop) begin
            n_ocnt = r_ocnt + 1'b1;
        end else if (!res_push && res_pop) begin
            n_ocnt = r_ocnt - 1'b1;
        end
    end

    assign o_empty      = (r_ocnt == '0);
    assign o_peak_level = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_peak  <= '0;
            r_owp   <= '0;
            r_orp   <= '0;
            r_ocnt  <= '0;
        end else begin
            if (step) begin
                r_phase <= n_phase;
                r_peak  <= n_peak;
            end
            if (res_push) begin
                r_owp <= r_owp + 1'b1;
            end
            if (res_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_owp] <= r_peak;
        end
    end

    a_emit_from_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (r_phase == PH_FALL && r_peak != '0))
        else $error("result written outside a confirmed fall");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |=> (r_phase == PH_QUIET || r_phase == PH_RISE))
        else $error("phase after emit is wrong");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("result queue count out of range");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the accelerometer spike peak detector
// ----------------------------------------------------------------------------
// samples go in through the push/full port and peak levels come back through
// the pop/empty port. a scoreboard class tracks the spike phase machine and
// thresholds and queues the expected peak level of each spike. a short
// directed run walks every phase with edge samples. random phases follow; all
// but the first reprogram the thresholds over the apb port, including extreme
// and unordered settings, and all send mostly well-formed spikes mixed with noise.
// either side idles at random. a watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         STALL_LIMIT = 1000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 168;

    typedef enum logic [2:0] {
        SP_IDLE,
        SP_ARM,
        SP_RISE,
        SP_FALL,
        SP_QUIET
    } spike_phase_e;

    class peak_scoreboard;
        logic [7:0]   thr3;
        logic [7:0]   thr2;
        logic [7:0]   thr1;
        spike_phase_e phase;
        logic [1:0]   peak;
        logic [1:0]   pending_peaks[$];
        int           mismatches;

        function new();
            thr3       = aspd_pkg::LVL3_THR_RST;
            thr2       = aspd_pkg::LVL2_THR_RST;
            thr1       = aspd_pkg::LVL1_THR_RST;
            phase      = SP_IDLE;
            peak       = 2'd0;
            mismatches = 0;
        endfunction

        function void set_threshold(logic [1:0] idx, logic [7:0] val);
            case (idx)
                aspd_pkg::REG_LVL3_THR: thr3 = val;
                aspd_pkg::REG_LVL2_THR: thr2 = val;
                aspd_pkg::REG_LVL1_THR: thr1 = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] axis_mag(logic [7:0] v);
            return v[7] ? (~v + 8'd1) : v;
        endfunction

        function logic [1:0] level_of(logic [7:0] mag);
            if (mag > thr3) return 2'd3;
            if (mag > thr2) return 2'd2;
            if (mag > thr1) return 2'd1;
            return 2'd0;
        endfunction

        function void note_sample(logic [7:0] x, logic [7:0] y, logic [7:0] z);
            logic [7:0] mag;
            logic [1:0] lvl;
            mag = axis_mag(x);
            if (axis_mag(y) > mag) mag = axis_mag(y);
            if (axis_mag(z) > mag) mag = axis_mag(z);
            lvl = level_of(mag);
            case (phase)
                SP_IDLE: begin
                    if (lvl != 2'd0) begin
                        phase = SP_ARM;
                        peak  = 2'd0;
                    end
                end
                SP_ARM: begin
                    if (lvl != 2'd0) begin
                        phase = SP_RISE;
                        peak  = lvl;
                    end else begin
                        phase = SP_IDLE;
                    end
                end
                SP_RISE: begin
                    if (lvl < peak) phase = SP_FALL;
                    if (peak < lvl) peak = lvl;
                end
                SP_FALL: begin
                    if (lvl < peak) begin
                        phase = SP_QUIET;
                        pending_peaks.push_back(peak);
                        peak = 2'd0;
                    end
                    if (lvl > peak) begin
                        phase = SP_RISE;
                        peak  = lvl;
                    end
                end
                SP_QUIET: begin
                    if (lvl == 2'd0) begin
                        if (peak != 2'd0) peak = 2'd0;
                        else phase = SP_IDLE;
                    end
                end
                default: phase = SP_IDLE;
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("peak mismatch: %s", msg);
        endfunction

        function void check_peak(logic [1:0] got);
            logic [1:0] want;
            if (pending_peaks.size() == 0) begin
                flag($sformatf("unexpected word, peak level %0d", got));
            end else begin
                want = pending_peaks.pop_front();
                if (got !== want) flag($sformatf("expected peak level %0d, got %0d", want, got));
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_push;
    logic                                o_full;
    logic signed [aspd_pkg::SAMPLE_W-1:0] i_accel_x;
    logic signed [aspd_pkg::SAMPLE_W-1:0] i_accel_y;
    logic signed [aspd_pkg::SAMPLE_W-1:0] i_accel_z;
    logic                                o_empty;
    logic                                i_pop;
    logic [aspd_pkg::LEVEL_W-1:0]        o_peak_level;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [aspd_pkg::APB_AW-1:0]         paddr;
    logic [aspd_pkg::APB_DW-1:0]         pwdata;
    logic [aspd_pkg::APB_DW-1:0]         prdata;
    logic                                pready;

    peak_scoreboard sb;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             items_sent     = 0;
    int             quiet_cycles   = 0;

    accel_spike_peak_detector_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_peak_level (o_peak_level),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // handshakes are judged at the falling edge, where every signal is settled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) sb.check_peak(o_peak_level);
            if (i_push && !o_full) sb.note_sample(i_accel_x, i_accel_y, i_accel_z);
            if ((i_pop && !o_empty) || (i_push && !o_full)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_accel_x <= x;
        i_accel_y <= y;
        i_accel_z <= z;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_full;
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    function automatic logic [7:0] signed_axis(logic [7:0] m);
        if (m == 8'd128 || $urandom_range(0, 1) == 1) return ~m + 8'd1;
        return m;
    endfunction

    task automatic send_level(input logic [1:0] want);
        logic [7:0] mag;
        logic [7:0] axes[3];
        int         main_axis;
        int         tries;
        int         a;
        mag = 8'($urandom_range(0, 128));
        for (tries = 0; tries < 40 && sb.level_of(mag) != want; tries++)
            mag = 8'($urandom_range(0, 128));
        main_axis = $urandom_range(0, 2);
        for (a = 0; a < 3; a++)
            axes[a] = signed_axis(a == main_axis ? mag : 8'($urandom_range(0, mag)));
        send_sample(axes[0], axes[1], axes[2]);
    endtask

    task automatic run_spike_burst();
        int n;
        if ($urandom_range(0, 99) < 80) begin
            n = $urandom_range(0, 2);
            repeat (n) send_level(2'd0);
            n = $urandom_range(1, 4);
            repeat (n) send_level(2'($urandom_range(1, 3)));
            n = $urandom_range(1, 3);
            repeat (n) send_level(2'($urandom_range(0, 2)));
            n = $urandom_range(1, 3);
            repeat (n) send_level(2'd0);
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) send_sample(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_threshold(idx, val);
        @(posedge i_clk);
    endtask

    task automatic settle_block();
        i_push <= 1'b0;
        while (sb.pending_peaks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    logic [23:0] directed_words[] = '{
        24'h000000, 24'h7f8001, 24'hff0000, 24'h800000, 24'h006400, 24'h00007f,
        24'h5f0000, 24'h5b0000, 24'h000000, 24'h0000a5, 24'h000000, 24'h5aa65a,
        24'h820000, 24'h7e0000, 24'h000000, 24'h000000, 24'h640000, 24'h000000,
        24'h837d83, 24'h000000, 24'h55aa00, 24'haa55ff
    };

    initial begin
        logic [7:0] t3;
        logic [7:0] t2;
        logic [7:0] t1;
        int         p;
        sb        = new();
        i_rst_n   <= 1'b0;
        i_push    <= 1'b0;
        i_accel_x <= '0;
        i_accel_y <= '0;
        i_accel_z <= '0;
        i_pop     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[i])
            send_sample(directed_words[i][23:16], directed_words[i][15:8],
                        directed_words[i][7:0]);

        for (p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                settle_block();
                case (p)
                    1: begin t3 = 8'd100; t2 = 8'd60;  t1 = 8'd20;  end
                    2: begin t3 = 8'd0;   t2 = 8'd0;   t1 = 8'd0;   end
                    3: begin t3 = 8'd255; t2 = 8'd128; t1 = 8'd0;   end
                    4: begin t3 = 8'd20;  t2 = 8'd60;  t1 = 8'd100; end
                    default: begin
                        t3 = 8'($urandom_range(0, 135));
                        t2 = 8'($urandom_range(0, 135));
                        t1 = 8'($urandom_range(0, 135));
                    end
                endcase
                apb_write(aspd_pkg::REG_LVL3_THR, t3);
                apb_write(aspd_pkg::REG_LVL2_THR, t2);
                apb_write(aspd_pkg::REG_LVL1_THR, t1);
                apb_write(REG_SPARE, 8'($urandom));
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) run_spike_burst();
        end

        settle_block();
        if (sb.mismatches == 0 && sb.pending_peaks.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
